FILE: hdl/rcf_pkg.sv
package rcf_pkg;

	localparam int DEPTH_DEFAULT = 1024;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;
	localparam int CAP_W = 12;
	localparam int START_W = 11;

	localparam logic [CAP_W-1:0] CAP_MAX = 12'd4095;
	localparam logic [CAP_W-1:0] CAP_EMPTY = 12'd2;
	localparam logic [CAP_W-1:0] CAP_MIN = 12'd1;
	localparam logic [CAP_W-1:0] CAP_RESET = 12'd2;

	typedef enum logic [2:0] {
		OP_ENQUEUE    = 3'd0,
		OP_DEQUEUE    = 3'd1,
		OP_PEEK_FRONT = 3'd2,
		OP_PEEK_BACK  = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]                opcode;
		logic signed [VALUE_W-1:0] item_value;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		logic [1:0]                status;
		logic [COUNT_W-1:0]        item_count;
		logic [CAP_W-1:0]          logical_capacity;
	} out_word_t;

endpackage

FILE: hdl/rcf_ring.sv
module rcf_ring #(
	parameter int DEPTH = rcf_pkg::DEPTH_DEFAULT,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [AW-1:0]               addr,
	input  logic [rcf_pkg::VALUE_W-1:0] wdata,
	output logic [rcf_pkg::VALUE_W-1:0] rdata
);

	logic [rcf_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: hdl/rcf_ctrl.sv
module rcf_ctrl #(
	parameter int DEPTH = rcf_pkg::DEPTH_DEFAULT,
	parameter int AW = $clog2(DEPTH),
	parameter int CW = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  rcf_pkg::in_word_t           in_data,
	input  logic                        cfg_wen,
	input  logic [rcf_pkg::START_W-1:0] cfg_wdata,
	output logic                        mem_we,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_addr,
	output logic [rcf_pkg::VALUE_W-1:0] mem_wdata,
	output logic                        use_mem,
	output rcf_pkg::out_word_t          res
);

	localparam int CMPW = (CW + 2 > rcf_pkg::CAP_W) ? CW + 2 : rcf_pkg::CAP_W;
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [AW-1:0]               head_q, head_d;
	logic [CW-1:0]               count_q, count_d;
	logic [rcf_pkg::CAP_W-1:0]   cap_q, cap_d;
	logic [AW-1:0]               tail_addr, next_head, last_addr;
	logic [CW-1:0]               count_dec;
	logic [rcf_pkg::CAP_W:0]     cap_dbl;
	logic [rcf_pkg::CAP_W-1:0]   start_cap;
	logic                        is_empty;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	assign count_dec = count_q - ONE_C;
	assign tail_addr = wrap_add(head_q, count_q[AW-1:0]);
	assign last_addr = wrap_add(head_q, count_dec[AW-1:0]);
	assign next_head = wrap_add(head_q, AW'(1));
	assign is_empty = (count_q == '0);
	assign cap_dbl = {cap_q, 1'b0};
	assign start_cap = (cfg_wdata == '0) ? rcf_pkg::CAP_MIN
		: rcf_pkg::CAP_W'(cfg_wdata);

	always_comb begin
		head_d = head_q;
		count_d = count_q;
		cap_d = cap_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = head_q;
		mem_wdata = in_data.item_value;
		use_mem = 1'b0;
		res.result_value = '0;
		res.status = rcf_pkg::ST_OK;
		case (rcf_pkg::op_t'(in_data.opcode))
			rcf_pkg::OP_ENQUEUE: begin
				if (count_q == DEPTH_C) begin
					res.status = rcf_pkg::ST_FULL;
				end else begin
					if (CMPW'(count_q) == CMPW'(cap_q)) begin
						cap_d = (cap_dbl > {1'b0, rcf_pkg::CAP_MAX}) ? rcf_pkg::CAP_MAX
							: cap_dbl[rcf_pkg::CAP_W-1:0];
					end
					mem_we = accept;
					mem_addr = tail_addr;
					count_d = count_q + ONE_C;
				end
			end
			rcf_pkg::OP_DEQUEUE: begin
				if (is_empty) begin
					res.result_value = '1;
					res.status = rcf_pkg::ST_EMPTY;
				end else begin
					mem_re = accept;
					use_mem = 1'b1;
					mem_addr = head_q;
					if (count_q == ONE_C) begin
						head_d = '0;
						count_d = '0;
						cap_d = rcf_pkg::CAP_EMPTY;
					end else begin
						head_d = next_head;
						count_d = count_dec;
						if ({CMPW'(count_dec), 2'b00} <= {2'b00, CMPW'(cap_q)}) begin
							cap_d = cap_q >> 1;
						end
					end
				end
			end
			rcf_pkg::OP_PEEK_FRONT, rcf_pkg::OP_PEEK_BACK: begin
				if (is_empty) begin
					res.result_value = '1;
					res.status = rcf_pkg::ST_EMPTY;
				end else begin
					mem_re = accept;
					use_mem = 1'b1;
					mem_addr = (in_data.opcode == rcf_pkg::OP_PEEK_FRONT) ? head_q
						: last_addr;
				end
			end
			rcf_pkg::OP_CLEAR: begin
				head_d = '0;
				count_d = '0;
				cap_d = rcf_pkg::CAP_EMPTY;
			end
			default: begin
			end
		endcase
		res.item_count = rcf_pkg::COUNT_W'(count_d);
		res.logical_capacity = cap_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			cap_q <= rcf_pkg::CAP_RESET;
		end else if (cfg_wen) begin
			head_q <= '0;
			count_q <= '0;
			cap_q <= start_cap;
		end else if (accept) begin
			head_q <= head_d;
			count_q <= count_d;
			cap_q <= cap_d;
		end
	end

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("item count beyond storage depth");

	ap_cap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q != '0)
		else $error("logical capacity reached zero");

	ap_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("ring read and write in the same cycle");

	ap_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_wen && in_data.opcode == rcf_pkg::OP_CLEAR
		|=> count_q == '0 && head_q == '0 && cap_q == rcf_pkg::CAP_EMPTY)
		else $error("clear left the queue non-empty");

endmodule

FILE: hdl/resizing_circular_fifo.sv
// resizing fifo of signed 32-bit words in a ring of DEPTH entries
// in channel: in_valid / in_ready, in_data carries opcode and item_value;
//   opcodes are enqueue, dequeue, peek front, peek back and clear
// out channel: out_valid / out_ready, out_data carries the result word,
//   status, item count and logical capacity after the operation
// every accepted word gives exactly one result word
// a word passes the ring read stage, then the output register, before out_valid;
//   one word per cycle while in_ready is high, set by the single ring port
//   since each operation reads or writes at most one entry
// logical capacity doubles on an enqueue at count == capacity (saturating at
//   4095), halves after a dequeue leaving 4*count <= capacity, and returns to
//   2 on emptying or clear
// start_capacity_wen loads start_capacity (zero taken as 1) and empties the
//   queue; write it only while no word is in flight
// reset: queue empty, capacity 2; ring contents are not cleared
// a stalled receiver holds the output register; one further word can sit in
//   the read stage, after which in_ready drops
module resizing_circular_fifo #(
	parameter int DEPTH = rcf_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rcf_pkg::in_word_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rcf_pkg::out_word_t          out_data,
	input  logic                        start_capacity_wen,
	input  logic [rcf_pkg::START_W-1:0] start_capacity
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                        accept;
	logic                        mem_we, mem_re, use_mem;
	logic [AW-1:0]               mem_addr;
	logic [rcf_pkg::VALUE_W-1:0] mem_wdata, mem_rdata;
	rcf_pkg::out_word_t          res;
	rcf_pkg::out_word_t          res_s1;
	rcf_pkg::out_word_t          res_mux;
	logic                        valid_s1, use_mem_s1;
	rcf_pkg::out_word_t          out_q;
	logic                        out_valid_q;
	logic                        advance;

	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept = in_valid && in_ready;

	rcf_ctrl #(
		.DEPTH(DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_data(in_data),
		.cfg_wen(start_capacity_wen),
		.cfg_wdata(start_capacity),
		.mem_we(mem_we),
		.mem_re(mem_re),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.use_mem(use_mem),
		.res(res)
	);

	rcf_ring #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ring (
		.clk(clk),
		.we(mem_we),
		.re(mem_re),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			use_mem_s1 <= use_mem;
		end
	end

	always_comb begin
		res_mux = res_s1;
		if (use_mem_s1) begin
			res_mux.result_value = mem_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res_mux;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

FILE: verif/tb_resizing_circular_fifo.sv
`timescale 1ns / 1ps

module tb_resizing_circular_fifo;

	localparam int DEPTH = rcf_pkg::DEPTH_DEFAULT;
	localparam int HALF_PERIOD = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_WORDS = 120;
	localparam int WRAP_WORDS = 40;
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam logic [rcf_pkg::VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [rcf_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [rcf_pkg::VALUE_W-1:0] VAL_ALL_ONES = 32'hffff_ffff;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	rcf_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	rcf_pkg::out_word_t out_data;
	logic start_capacity_wen;
	logic [rcf_pkg::START_W-1:0] start_capacity;

	// queue state mirror
	logic [rcf_pkg::VALUE_W-1:0] shadow_ring [DEPTH];
	int unsigned shadow_head;
	int unsigned shadow_count;
	int unsigned shadow_cap;

	rcf_pkg::out_word_t pending_results [$];
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off_req;
	int hold_off_left;
	int error_count;
	int words_sent;
	int results_seen;
	int capacity_writes;
	int quiet_cycles;

	resizing_circular_fifo u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.in_data            (in_data),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.out_data           (out_data),
		.start_capacity_wen (start_capacity_wen),
		.start_capacity     (start_capacity)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	function automatic rcf_pkg::out_word_t predict_fifo_result(rcf_pkg::in_word_t w);
		rcf_pkg::out_word_t r;
		r = '0;
		r.status = rcf_pkg::ST_OK;
		case (w.opcode)
			rcf_pkg::OP_ENQUEUE: begin
				if (shadow_count >= DEPTH) begin
					r.status = rcf_pkg::ST_FULL;
				end else begin
					if (shadow_count == shadow_cap)
						shadow_cap = (shadow_cap * 2 > rcf_pkg::CAP_MAX) ? rcf_pkg::CAP_MAX
							: shadow_cap * 2;
					shadow_ring[(shadow_head + shadow_count) % DEPTH] = w.item_value;
					shadow_count++;
				end
			end
			rcf_pkg::OP_DEQUEUE: begin
				if (shadow_count == 0) begin
					r.result_value = VAL_ALL_ONES;
					r.status = rcf_pkg::ST_EMPTY;
				end else begin
					r.result_value = shadow_ring[shadow_head];
					if (shadow_count == 1) begin
						shadow_head = 0;
						shadow_count = 0;
						shadow_cap = rcf_pkg::CAP_EMPTY;
					end else begin
						shadow_head = (shadow_head + 1) % DEPTH;
						shadow_count--;
						if (4 * shadow_count <= shadow_cap)
							shadow_cap = shadow_cap / 2;
					end
				end
			end
			rcf_pkg::OP_PEEK_FRONT, rcf_pkg::OP_PEEK_BACK: begin
				if (shadow_count == 0) begin
					r.result_value = VAL_ALL_ONES;
					r.status = rcf_pkg::ST_EMPTY;
				end else if (w.opcode == rcf_pkg::OP_PEEK_FRONT) begin
					r.result_value = shadow_ring[shadow_head];
				end else begin
					r.result_value = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
				end
			end
			rcf_pkg::OP_CLEAR: begin
				shadow_head = 0;
				shadow_count = 0;
				shadow_cap = rcf_pkg::CAP_EMPTY;
			end
			default: begin
			end
		endcase
		r.item_count = rcf_pkg::COUNT_W'(shadow_count);
		r.logical_capacity = rcf_pkg::CAP_W'(shadow_cap);
		return r;
	endfunction

	function automatic rcf_pkg::in_word_t make_word(logic [2:0] op,
			logic [rcf_pkg::VALUE_W-1:0] v);
		rcf_pkg::in_word_t w;
		w.opcode = op;
		w.item_value = v;
		return w;
	endfunction

	function automatic logic [rcf_pkg::VALUE_W-1:0] random_value();
		logic [rcf_pkg::VALUE_W-1:0] v;
		case ($urandom_range(7))
			0: v = VAL_MAX;
			1: v = VAL_MIN;
			2: v = VAL_ALL_ONES;
			3: v = '0;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic rcf_pkg::in_word_t random_word(int enq_pct);
		int pick;
		logic [2:0] op;
		pick = $urandom_range(99);
		if (pick < enq_pct) begin
			op = rcf_pkg::OP_ENQUEUE;
		end else begin
			pick = $urandom_range(99);
			if (pick < 55)
				op = rcf_pkg::OP_DEQUEUE;
			else if (pick < 75)
				op = rcf_pkg::OP_PEEK_FRONT;
			else if (pick < 93)
				op = rcf_pkg::OP_PEEK_BACK;
			else if (pick < 96)
				op = rcf_pkg::OP_CLEAR;
			else
				op = 3'($urandom_range(OP_SPARE_7, OP_SPARE_5));
		end
		return make_word(op, random_value());
	endfunction

	task automatic send_word(rcf_pkg::in_word_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_fifo_result(w));
		words_sent++;
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_start_capacity(logic [rcf_pkg::START_W-1:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		start_capacity_wen <= 1'b1;
		start_capacity <= v;
		@(posedge clk);
		start_capacity_wen <= 1'b0;
		shadow_head = 0;
		shadow_count = 0;
		shadow_cap = (v == 0) ? rcf_pkg::CAP_MIN : v;
		capacity_writes++;
	endtask

	task automatic send_run(logic [2:0] op, int n);
		repeat (n) send_word(make_word(op, random_value()));
	endtask

	// empty accesses, spare opcodes, extremes, doubling and halving
	task automatic test_basic_ops();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_word(make_word(rcf_pkg::OP_DEQUEUE, VAL_MAX));
		send_word(make_word(rcf_pkg::OP_PEEK_FRONT, '0));
		send_word(make_word(rcf_pkg::OP_PEEK_BACK, VAL_MIN));
		send_word(make_word(OP_SPARE_5, VAL_ALL_ONES));
		send_word(make_word(rcf_pkg::OP_ENQUEUE, VAL_MAX));
		send_word(make_word(rcf_pkg::OP_ENQUEUE, VAL_MIN));
		send_word(make_word(rcf_pkg::OP_ENQUEUE, VAL_ALL_ONES));
		send_word(make_word(rcf_pkg::OP_ENQUEUE, '0));
		send_word(make_word(rcf_pkg::OP_ENQUEUE, 32'h5555_5555));
		send_word(make_word(rcf_pkg::OP_ENQUEUE, 32'haaaa_aaaa));
		send_word(make_word(rcf_pkg::OP_PEEK_FRONT, '0));
		send_word(make_word(rcf_pkg::OP_PEEK_BACK, '0));
		send_word(make_word(OP_SPARE_6, 32'h1234_5678));
		send_word(make_word(OP_SPARE_7, VAL_MIN));
		send_run(rcf_pkg::OP_DEQUEUE, 4);
		send_word(make_word(rcf_pkg::OP_CLEAR, VAL_MAX));
		send_word(make_word(rcf_pkg::OP_DEQUEUE, '0));
		send_word(make_word(rcf_pkg::OP_PEEK_BACK, '0));
		end_burst();
	endtask

	task automatic test_capacity_extremes();
		write_start_capacity('0);
		send_run(rcf_pkg::OP_ENQUEUE, 3);
		send_run(rcf_pkg::OP_DEQUEUE, 3);
		end_burst();
		write_start_capacity({rcf_pkg::START_W{1'b1}});
		send_run(rcf_pkg::OP_ENQUEUE, 5);
		send_word(make_word(rcf_pkg::OP_PEEK_BACK, '0));
		send_run(rcf_pkg::OP_DEQUEUE, 2);
		end_burst();
		write_start_capacity(11'd1);
		send_run(rcf_pkg::OP_ENQUEUE, 2);
		send_word(make_word(rcf_pkg::OP_CLEAR, '0));
		send_run(rcf_pkg::OP_ENQUEUE, 3);
		end_burst();
	endtask

	// fill past the last capacity doubling, reject, then refill across the wrap
	task automatic test_full_and_wrap();
		send_idle_pct = 0;
		recv_stall_pct = 7;
		write_start_capacity(11'd1023);
		send_run(rcf_pkg::OP_ENQUEUE, DEPTH);
		send_word(make_word(rcf_pkg::OP_ENQUEUE, VAL_MAX));
		send_word(make_word(rcf_pkg::OP_PEEK_BACK, '0));
		send_run(rcf_pkg::OP_DEQUEUE, WRAP_WORDS);
		send_run(rcf_pkg::OP_ENQUEUE, WRAP_WORDS);
		send_word(make_word(rcf_pkg::OP_PEEK_FRONT, '0));
		send_word(make_word(rcf_pkg::OP_PEEK_BACK, '0));
		send_word(make_word(rcf_pkg::OP_ENQUEUE, VAL_MIN));
		send_run(rcf_pkg::OP_DEQUEUE, WRAP_WORDS);
		send_word(make_word(rcf_pkg::OP_CLEAR, '0));
		send_word(make_word(rcf_pkg::OP_DEQUEUE, '0));
		end_burst();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_start_capacity(11'd4);
		hold_off_req = 1'b1;
		repeat (60) send_word(random_word(60));
		end_burst();
	endtask

	// sender stops until every result is back, then carries on
	task automatic test_drain_pause();
		send_idle_pct = 7;
		recv_stall_pct = 83;
		repeat (20) send_word(random_word(70));
		end_burst();
		wait_drained();
		repeat (20) send_word(random_word(30));
		end_burst();
	endtask

	task automatic test_random_phase(logic [rcf_pkg::START_W-1:0] cap, int idle_pct,
			int stall_pct);
		int enq_pct;
		write_start_capacity(cap);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		enq_pct = 50;
		for (int i = 0; i < PHASE_WORDS; i++) begin
			if (i % 40 == 0)
				enq_pct = $urandom_range(80, 20);
			send_word(random_word(enq_pct));
		end
		end_burst();
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result word %h", out_data);
				error_count++;
			end else begin
				rcf_pkg::out_word_t exp_w;
				exp_w = pending_results.pop_front();
				if (out_data.result_value !== exp_w.result_value) begin
					$error("result_value: expected %0d, got %0d",
						exp_w.result_value, out_data.result_value);
					error_count++;
				end
				if (out_data.status !== exp_w.status) begin
					$error("status: expected %0d, got %0d", exp_w.status, out_data.status);
					error_count++;
				end
				if (out_data.item_count !== exp_w.item_count) begin
					$error("item_count: expected %0d, got %0d",
						exp_w.item_count, out_data.item_count);
					error_count++;
				end
				if (out_data.logical_capacity !== exp_w.logical_capacity) begin
					$error("logical_capacity: expected %0d, got %0d",
						exp_w.logical_capacity, out_data.logical_capacity);
					error_count++;
				end
			end
		end
	end

	// receiver readiness, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_off_req) begin
			hold_off_left = HOLD_OFF_CYCLES;
			hold_off_req = 1'b0;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		start_capacity_wen = 1'b0;
		start_capacity = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 1'b0;
		hold_off_left = 0;
		error_count = 0;
		words_sent = 0;
		results_seen = 0;
		capacity_writes = 0;
		quiet_cycles = 0;
		shadow_head = 0;
		shadow_count = 0;
		shadow_cap = rcf_pkg::CAP_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_capacity_extremes();
		test_full_and_wrap();
		test_backpressure();
		test_drain_pause();
		test_random_phase(11'd2, 0, 0);
		test_random_phase(11'd1024, 83, 0);
		test_random_phase(11'($urandom_range(1023, 3)), 0, 83);
		test_random_phase(11'd0, 7, 7);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			error_count++;
		end
		$display("run covered %0d words and %0d results over %0d start capacity writes",
			words_sent, results_seen, capacity_writes);
		$display("including empty, full, wrap-around, spare opcodes, hold-off and idle phases");
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
